// ===== rtl/wcc_pkg.sv =====
// Package with shared constants for the wall collision checker.
`timescale 1ns / 1ps
package wcc_pkg;
    localparam int MAX_WALLS_DEF = 64;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CW = 24;
    localparam logic [15:0] RADIUS_RST = 16'd768;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_LINE = 2'd3;
    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_COUNT = 1'b1;
endpackage

// ===== rtl/wcc_ram.sv =====
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module wcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/wcc_eval.sv =====
// Pipelined per-wall hit test: four register stages from wall data to hit kind.
`timescale 1ns / 1ps
module wcc_eval import wcc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_sx,
    input  logic signed [CW-1:0] i_sz,
    input  logic signed [CW-1:0] i_ex,
    input  logic signed [CW-1:0] i_ez,
    input  logic [CW-1:0]        i_len,
    input  logic [15:0]          i_radius,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cz,
    input  logic signed [CW-1:0] i_nx,
    input  logic signed [CW-1:0] i_nz,
    output logic                 o_valid,
    output logic [1:0]           o_kind
);
    // Stage 1: differences and range test.
    logic r1_v, r1_in;
    logic signed [CW:0] r1_dsx, r1_dsz, r1_dex, r1_dez, r1_dx, r1_dz;
    logic signed [CW:0] r1_csx, r1_csz;
    logic [CW-1:0] r1_len;
    logic [15:0] r1_r;
    logic signed [CW-1:0] lox, hix, loz, hiz;
    logic inx, inz;
    always_comb begin
        lox = (i_sx < i_ex) ? i_sx : i_ex;
        hix = (i_sx < i_ex) ? i_ex : i_sx;
        loz = (i_sz < i_ez) ? i_sz : i_ez;
        hiz = (i_sz < i_ez) ? i_ez : i_sz;
        inx = (i_cx > lox) && (i_cx < hix);
        inz = (i_cz > loz) && (i_cz < hiz);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else r1_v <= i_valid;
        r1_in  <= ((hix == lox) && inz) || ((hiz == loz) && inx) || (inx && inz);
        r1_dsx <= {i_nx[CW-1], i_nx} - {i_sx[CW-1], i_sx};
        r1_dsz <= {i_nz[CW-1], i_nz} - {i_sz[CW-1], i_sz};
        r1_dex <= {i_nx[CW-1], i_nx} - {i_ex[CW-1], i_ex};
        r1_dez <= {i_nz[CW-1], i_nz} - {i_ez[CW-1], i_ez};
        r1_dx  <= {i_ex[CW-1], i_ex} - {i_sx[CW-1], i_sx};
        r1_dz  <= {i_ez[CW-1], i_ez} - {i_sz[CW-1], i_sz};
        r1_csx <= {i_cx[CW-1], i_cx} - {i_sx[CW-1], i_sx};
        r1_csz <= {i_cz[CW-1], i_cz} - {i_sz[CW-1], i_sz};
        r1_len <= i_len;
        r1_r   <= i_radius;
    end
    // Stage 2: products.
    localparam int PW = 2 * (CW + 1);
    logic r2_v, r2_in;
    logic signed [PW-1:0] r2_ps1, r2_ps2, r2_pe1, r2_pe2;
    logic signed [PW-1:0] r2_an, r2_bn, r2_ac, r2_bc;
    logic [CW+15:0] r2_off;
    logic [31:0] r2_rr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else r2_v <= r1_v;
        r2_in  <= r1_in;
        r2_ps1 <= r1_dsx * r1_dsx;
        r2_ps2 <= r1_dsz * r1_dsz;
        r2_pe1 <= r1_dex * r1_dex;
        r2_pe2 <= r1_dez * r1_dez;
        r2_an  <= r1_dx * r1_dsz;
        r2_bn  <= r1_dz * r1_dsx;
        r2_ac  <= r1_dx * r1_csz;
        r2_bc  <= r1_dz * r1_csx;
        r2_off <= r1_len * r1_r;
        r2_rr  <= r1_r * r1_r;
    end
    // Stage 3: sums.
    localparam int SW = PW + 2;
    logic r3_v, r3_in, r3_hs, r3_he;
    logic signed [SW-1:0] r3_cn, r3_cc, r3_off;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else r3_v <= r2_v;
        r3_in  <= r2_in;
        r3_hs  <= ({2'b0, r2_ps1} + {2'b0, r2_ps2}) <= {{(SW-32){1'b0}}, r2_rr};
        r3_he  <= ({2'b0, r2_pe1} + {2'b0, r2_pe2}) <= {{(SW-32){1'b0}}, r2_rr};
        r3_cn  <= {{2{r2_an[PW-1]}}, r2_an} - {{2{r2_bn[PW-1]}}, r2_bn};
        r3_cc  <= {{2{r2_ac[PW-1]}}, r2_ac} - {{2{r2_bc[PW-1]}}, r2_bc};
        r3_off <= SW'(r2_off);
    end
    // Stage 4: offset line tests and priority.
    localparam int TW = SW + 1;
    logic signed [TW-1:0] np, cp, nm, cm;
    logic st_p, st_m;
    always_comb begin
        np = {r3_cn[SW-1], r3_cn} + {r3_off[SW-1], r3_off};
        cp = {r3_cc[SW-1], r3_cc} + {r3_off[SW-1], r3_off};
        nm = {r3_cn[SW-1], r3_cn} - {r3_off[SW-1], r3_off};
        cm = {r3_cc[SW-1], r3_cc} - {r3_off[SW-1], r3_off};
        st_p = !((np < 0) && (cp < 0)) && !((np > 0) && (cp > 0));
        st_m = !((nm < 0) && (cm < 0)) && !((nm > 0) && (cm > 0));
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r3_v;
        if (r3_hs) o_kind <= KIND_START;
        else if (r3_he) o_kind <= KIND_END;
        else if (r3_in && (st_p || st_m)) o_kind <= KIND_LINE;
        else o_kind <= KIND_NONE;
    end
endmodule

// ===== rtl/wall_collision_check.sv =====
// Top level of the wall collision checker: wall table, scan control and output register.
`timescale 1ns / 1ps
// A query scans walls 0 to wall_count-1 (wall_count capped at MAX_WALLS), issuing
// one wall read per cycle until a hit is found, into a five-stage test pipeline (RAM
// read plus four compute stages). One query is handled at a time; the result waits in
// an output register and the next word is taken once the result has been handed over.
module wall_collision_check import wcc_pkg::*; #(
    parameter int MAX_WALLS = MAX_WALLS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, lowest bit up: wall_index, wall_start_x, wall_start_z, wall_end_x,
    // wall_end_z, wall_length, cur_x, cur_z, next_x, next_z, zero fill
    input  logic [223:0] s_axis_tdata,
    // tuser: op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, lowest bit up: collision, hit_wall, hit_kind, zero fill
    output logic [15:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int NW = $clog2(MAX_WALLS + 1);
    localparam int LAT = 5;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_OUT} t_state;
    t_state r_state;

    logic [15:0] r_radius;
    logic [6:0]  r_count;
    logic [NW-1:0] r_limit, r_issue;
    logic signed [CW-1:0] r_cx, r_cz, r_nx, r_nz;
    logic [LAT-1:0] r_vpipe;
    logic [AW-1:0] r_ipipe [LAT];
    logic r_found;
    logic [5:0] r_hit;
    logic [1:0] r_kind;
    logic [NW-1:0] r_outst;

    wire s_acc = s_axis_tvalid && s_axis_tready;
    wire [5:0] w_idx = s_axis_tdata[5:0];
    wire load_we = s_acc && (s_axis_tuser == OP_LOAD) && ({26'd0, w_idx} < 32'(MAX_WALLS));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    logic [AW-1:0] rd_addr;
    assign rd_addr = r_issue[AW-1:0];
    logic [47:0] rd_s, rd_e;
    logic [CW-1:0] rd_l;

    wcc_ram #(.WIDTH(48), .DEPTH(MAX_WALLS)) u_starts (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(AW'(w_idx)),
        .i_wdata(s_axis_tdata[53:6]), .i_raddr(rd_addr), .o_rdata(rd_s));
    wcc_ram #(.WIDTH(48), .DEPTH(MAX_WALLS)) u_ends (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(AW'(w_idx)),
        .i_wdata(s_axis_tdata[101:54]), .i_raddr(rd_addr), .o_rdata(rd_e));
    wcc_ram #(.WIDTH(CW), .DEPTH(MAX_WALLS)) u_lens (
        .i_clk(i_clk), .i_we(load_we), .i_waddr(AW'(w_idx)),
        .i_wdata(s_axis_tdata[125:102]), .i_raddr(rd_addr), .o_rdata(rd_l));

    logic rd_v;
    assign rd_v = r_vpipe[0];
    logic ev_v;
    logic [1:0] ev_kind;
    wcc_eval u_eval (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(rd_v),
        .i_sx(rd_s[23:0]), .i_sz(rd_s[47:24]), .i_ex(rd_e[23:0]), .i_ez(rd_e[47:24]),
        .i_len(rd_l), .i_radius(r_radius),
        .i_cx(r_cx), .i_cz(r_cz), .i_nx(r_nx), .i_nz(r_nz),
        .o_valid(ev_v), .o_kind(ev_kind));

    logic [NW-1:0] n_limit;
    always_comb begin
        if ({25'd0, r_count} > 32'(MAX_WALLS)) n_limit = NW'(MAX_WALLS);
        else n_limit = NW'(r_count);
    end

    wire issue = (r_state == ST_SCAN) && (r_issue < r_limit) && !r_found;

    always_ff @(posedge i_clk) begin
        r_ipipe[0] <= rd_addr;
        for (int k = 1; k < LAT; k++) r_ipipe[k] <= r_ipipe[k-1];
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_radius <= RADIUS_RST;
            r_count <= 7'd0;
            r_vpipe <= '0;
            r_found <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_issue <= '0;
            r_limit <= '0;
            r_outst <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_COUNT:  r_count <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            r_vpipe <= {r_vpipe[LAT-2:0], issue};
            r_outst <= r_outst + NW'(issue) - NW'(ev_v);
            if (ev_v && ev_kind != KIND_NONE && !r_found) begin
                r_found <= 1'b1;
                r_hit <= 6'(r_ipipe[LAT-1]);
                r_kind <= ev_kind;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc && s_axis_tuser == OP_QUERY) begin
                        r_cx <= s_axis_tdata[149:126];
                        r_cz <= s_axis_tdata[173:150];
                        r_nx <= s_axis_tdata[197:174];
                        r_nz <= s_axis_tdata[221:198];
                        r_limit <= n_limit;
                        r_issue <= '0;
                        r_found <= 1'b0;
                        r_hit <= 6'd0;
                        r_kind <= KIND_NONE;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue) r_issue <= r_issue + 1'b1;
                    else r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (r_outst == '0 && r_vpipe == '0) begin
                        m_axis_tvalid <= 1'b1;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {7'd0, r_kind, r_hit, r_found};
endmodule
